/* design/circular_log_address_tracker_assert.svh */
// Assertion macros shared by the tracker modules.
`ifndef CIRCULAR_LOG_ADDRESS_TRACKER_ASSERT_SVH
`define CIRCULAR_LOG_ADDRESS_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CLAT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/clat_pkg.sv */
`default_nettype none

package clat_pkg;

   // Limits of the store geometry and of one log
   localparam logic [12:0] MAX_DIRS          = 13'd64;
   localparam logic [12:0] MAX_FILES_PER_DIR = 13'd64;
   localparam logic [12:0] MAX_LOGS_PER_FILE = 13'd4096;
   localparam logic [8:0]  MAX_LOG_BYTES     = 9'd256;
   localparam logic [19:0] POS_MAX           = 20'hFFFFF;

   // Width of files_per_dir * logs_per_file (at most 2^18)
   localparam int PD_W = 19;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_NUM_DIRS      = 2'd0;
   localparam logic [1:0] REG_FILES_PER_DIR = 2'd1;
   localparam logic [1:0] REG_LOGS_PER_FILE = 2'd2;

   // Position part of a pointer (the id is kept apart)
   typedef struct packed {
      logic [5:0]  dir;
      logic [5:0]  file;
      logic [11:0] line;
      logic [19:0] offset;
   } ptr_type;

   typedef struct packed {
      ptr_type ptr;
      logic    wrapped;
   } adv_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic div_start;
      logic div_step;
      logic adjust;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_drop;
      logic div_done;
      logic out_free;
   } sts_type;

   // 0 acts as 1, anything above the maximum acts as the maximum
   function automatic logic [12:0] clamp_reg(logic [12:0] v, logic [12:0] maxv);
      logic [12:0] r;
      if (v == 13'd0) r = 13'd1;
      else if (v > maxv) r = maxv;
      else r = v;
      return r;
   endfunction

   // One log step: line wraps into file, file into directory
   function automatic adv_type advance_ptr(ptr_type p, logic [8:0] len, logic [6:0] nd,
                                           logic [6:0] fpd, logic [12:0] lpf);
      logic [20:0] pos;
      logic [12:0] line_nx;
      logic [6:0]  file_nx;
      logic [6:0]  dir_nx;
      adv_type     r;
      pos     = {1'b0, p.offset} + {12'd0, len};
      line_nx = {1'b0, p.line} + 13'd1;
      file_nx = {1'b0, p.file} + 7'd1;
      dir_nx  = {1'b0, p.dir} + 7'd1;
      r.wrapped    = 1'b0;
      r.ptr.dir    = p.dir;
      r.ptr.file   = p.file;
      r.ptr.line   = line_nx[11:0];
      r.ptr.offset = pos[20] ? POS_MAX : pos[19:0];
      if (line_nx >= lpf) begin
         r.ptr.offset = 20'd0;
         r.ptr.line   = 12'd0;
         r.ptr.file   = file_nx[5:0];
         if (file_nx >= fpd) begin
            r.ptr.file = 6'd0;
            r.ptr.dir  = (dir_nx >= nd) ? 6'd0 : dir_nx[5:0];
            r.wrapped  = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/clat_csr.sv */
`default_nettype none

module clat_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output logic [6:0]       num_dirs,
   output logic [6:0]       files_per_dir,
   output logic [12:0]      logs_per_file
);
   import clat_pkg::*;

   logic [6:0]  num_dirs_ff, num_dirs_in;
   logic [6:0]  files_per_dir_ff, files_per_dir_in;
   logic [12:0] logs_per_file_ff, logs_per_file_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Register writes
   always_comb begin
      num_dirs_in      = num_dirs_ff;
      files_per_dir_in = files_per_dir_ff;
      logs_per_file_in = logs_per_file_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_NUM_DIRS:      num_dirs_in      = pwdata[6:0];
            REG_FILES_PER_DIR: files_per_dir_in = pwdata[6:0];
            REG_LOGS_PER_FILE: logs_per_file_in = pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dirs_ff      <= 7'd1;
         files_per_dir_ff <= 7'd1;
         logs_per_file_ff <= 13'd1;
      end else begin
         num_dirs_ff      <= num_dirs_in;
         files_per_dir_ff <= files_per_dir_in;
         logs_per_file_ff <= logs_per_file_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[3:2])
         REG_NUM_DIRS:      prdata = {25'd0, num_dirs_ff};
         REG_FILES_PER_DIR: prdata = {25'd0, files_per_dir_ff};
         REG_LOGS_PER_FILE: prdata = {19'd0, logs_per_file_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign num_dirs      = num_dirs_ff;
   assign files_per_dir = files_per_dir_ff;
   assign logs_per_file = logs_per_file_ff;

endmodule

`default_nettype wire

/* design/clat_ctrl.sv */
`default_nettype none

module clat_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire clat_pkg::sts_type sts,
   output clat_pkg::cmd_type      cmd
);
   import clat_pkg::*;

   `include "circular_log_address_tracker_assert.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_ADJ  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: take item, step, optional remainder pass, deliver
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_drop) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_ADJ;
         end
         S_ADJ: begin
            cmd.adjust = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   `CLAT_ASSERT_NEXT(a_take_to_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC, "accepted item did not start")
   `CLAT_ASSERT_NEXT(a_div_to_adj, clock, reset, (state_ff == S_DIV) && sts.div_done, state_ff == S_ADJ, "remainder pass did not end")

endmodule

`default_nettype wire

/* design/clat_dp.sv */
`default_nettype none

module clat_dp #(
   parameter int ID_BITS = 48
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire clat_pkg::cmd_type   cmd,
   output clat_pkg::sts_type        sts,
   input  wire logic                req_action,
   input  wire logic [8:0]          req_log_length,
   input  wire logic [6:0]          num_dirs,
   input  wire logic [6:0]          files_per_dir,
   input  wire logic [12:0]         logs_per_file,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_status,
   output logic [ID_BITS-1:0]       rsp_log_id,
   output logic [5:0]               rsp_at_dir,
   output logic [5:0]               rsp_at_file,
   output logic [11:0]              rsp_at_line,
   output logic [19:0]              rsp_at_position,
   output logic                     rsp_more_pending,
   output logic                     rsp_clear_dir_valid,
   output logic [5:0]               rsp_clear_dir_index,
   output logic                     rsp_checkpoint_due,
   output logic                     rsp_oldest_dropped
);
   import clat_pkg::*;

   `include "circular_log_address_tracker_assert.svh"

   localparam int CNT_W = $clog2(ID_BITS);

   // Item registers
   logic             act_ff;
   logic [8:0]       len_ff;

   // Pointers
   logic [ID_BITS-1:0] wr_id_ff, rd_id_ff;
   ptr_type            wr_ptr_ff, rd_ptr_ff;

   // Staged result
   logic               res_status_ff;
   logic [ID_BITS-1:0] res_id_ff;
   ptr_type            res_ptr_ff;
   logic               res_clear_ff;
   logic [5:0]         res_clear_idx_ff;
   logic               res_ckpt_ff;
   logic               res_drop_ff;

   // Remainder unit
   logic [ID_BITS-1:0] div_num_ff;
   logic [PD_W-1:0]    div_rem_ff;
   logic [CNT_W-1:0]   div_cnt_ff;
   logic [PD_W-1:0]    per_dir_ff;

   // Output register
   logic               rsp_valid_ff;
   logic               out_status_ff;
   logic [ID_BITS-1:0] out_id_ff;
   ptr_type            out_ptr_ff;
   logic               out_more_ff;
   logic               out_clear_ff;
   logic [5:0]         out_clear_idx_ff;
   logic               out_ckpt_ff;
   logic               out_drop_ff;

   logic [6:0]         nd, fpd;
   logic [12:0]        lpf;
   logic [12:0]        nd_w, fpd_w;
   logic [ID_BITS-1:0] id_diff;
   logic               pend;
   ptr_type            sel_ptr;
   adv_type            adv;
   logic               refused;
   logic               need_drop;
   logic [19:0]        prod;
   logic [PD_W-1:0]    trial;
   logic [PD_W-1:0]    gap;
   logic [6:0]         rd_dir_nx;

   // Effective geometry
   assign nd_w  = clamp_reg({6'd0, num_dirs}, MAX_DIRS);
   assign fpd_w = clamp_reg({6'd0, files_per_dir}, MAX_FILES_PER_DIR);
   assign nd    = nd_w[6:0];
   assign fpd   = fpd_w[6:0];
   assign lpf   = clamp_reg(logs_per_file, MAX_LOGS_PER_FILE);

   // Unread logs exist when wr - rd is nonzero and not negative
   assign id_diff = wr_id_ff - rd_id_ff;
   assign pend    = (id_diff != '0) && !id_diff[ID_BITS-1];

   // Step of the selected pointer
   assign sel_ptr   = act_ff ? rd_ptr_ff : wr_ptr_ff;
   assign adv       = advance_ptr(sel_ptr, len_ff, nd, fpd, lpf);
   assign refused   = act_ff && !pend;
   assign need_drop = !act_ff && adv.wrapped && (adv.ptr.dir == rd_ptr_ff.dir);

   assign prod      = {13'd0, fpd} * {7'd0, lpf};
   assign trial     = {div_rem_ff[PD_W-2:0], div_num_ff[ID_BITS-1]};
   assign gap       = per_dir_ff - div_rem_ff;
   assign rd_dir_nx = {1'b0, rd_ptr_ff.dir} + 7'd1;

   assign sts.need_drop = need_drop;
   assign sts.div_done  = (div_cnt_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         act_ff <= req_action;
         len_ff <= (req_log_length > MAX_LOG_BYTES) ? MAX_LOG_BYTES : req_log_length;
      end
   end

   // Pointers: step on exec, realign read pointer on drop
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_id_ff  <= '0;
         rd_id_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else if (cmd.exec && !refused) begin
         if (act_ff) begin
            rd_id_ff  <= rd_id_ff + 1'b1;
            rd_ptr_ff <= adv.ptr;
         end else begin
            wr_id_ff  <= wr_id_ff + 1'b1;
            wr_ptr_ff <= adv.ptr;
         end
      end else if (cmd.adjust) begin
         rd_id_ff         <= rd_id_ff + ID_BITS'(gap);
         rd_ptr_ff.offset <= 20'd0;
         rd_ptr_ff.line   <= 12'd0;
         rd_ptr_ff.file   <= 6'd0;
         rd_ptr_ff.dir    <= (rd_dir_nx >= nd) ? 6'd0 : rd_dir_nx[5:0];
      end
   end

   // Staged result
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (refused) begin
            res_status_ff    <= 1'b1;
            res_id_ff        <= '0;
            res_ptr_ff       <= '0;
            res_clear_ff     <= 1'b0;
            res_clear_idx_ff <= 6'd0;
            res_ckpt_ff      <= 1'b0;
            res_drop_ff      <= 1'b0;
         end else begin
            res_status_ff    <= 1'b0;
            res_id_ff        <= act_ff ? rd_id_ff : wr_id_ff;
            res_ptr_ff       <= sel_ptr;
            res_clear_ff     <= !act_ff && adv.wrapped;
            res_clear_idx_ff <= (!act_ff && adv.wrapped) ? adv.ptr.dir : 6'd0;
            res_ckpt_ff      <= !act_ff && (adv.ptr.line == 12'd0);
            res_drop_ff      <= need_drop;
         end
      end
   end

   // Remainder of rd_id by the directory size, one dividend bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_num_ff <= rd_id_ff;
         div_rem_ff <= '0;
         div_cnt_ff <= CNT_W'(ID_BITS - 1);
         per_dir_ff <= prod[PD_W-1:0];
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[ID_BITS-2:0], 1'b0};
         div_rem_ff <= (trial >= per_dir_ff) ? (trial - per_dir_ff) : trial;
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff    <= res_status_ff;
         out_id_ff        <= res_id_ff;
         out_ptr_ff       <= res_ptr_ff;
         out_more_ff      <= pend;
         out_clear_ff     <= res_clear_ff;
         out_clear_idx_ff <= res_clear_idx_ff;
         out_ckpt_ff      <= res_ckpt_ff;
         out_drop_ff      <= res_drop_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_log_id          = out_id_ff;
   assign rsp_at_dir          = out_ptr_ff.dir;
   assign rsp_at_file         = out_ptr_ff.file;
   assign rsp_at_line         = out_ptr_ff.line;
   assign rsp_at_position     = out_ptr_ff.offset;
   assign rsp_more_pending    = out_more_ff;
   assign rsp_clear_dir_valid = out_clear_ff;
   assign rsp_clear_dir_index = out_clear_idx_ff;
   assign rsp_checkpoint_due  = out_ckpt_ff;
   assign rsp_oldest_dropped  = out_drop_ff;

   `CLAT_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready, "result overwritten before taken")
   `CLAT_ASSERT_NOW(a_drop_needs_clear, clock, reset, rsp_valid_ff && out_drop_ff, out_clear_ff && !out_status_ff, "drop without directory clear")

endmodule

`default_nettype wire

/* design/circular_log_address_tracker.sv */
`default_nettype none

// Tracks write and read pointers into a circular log store of num_dirs
// directories, each of files_per_dir files of logs_per_file lines. Each item
// writes or reads one log; its result tells where the log lies and what the
// host must do (empty a directory, save metadata). An accepted item is
// staged, then loaded into the output register once that is free. A write
// that wraps into the directory holding the read pointer takes a remainder
// pass and a read pointer adjust before its result is loaded, as the read
// id is rounded up through a remainder unit that retires one id bit per
// cycle. One item is in flight at a time; the finished result waits in an
// output register while the next item is accepted. Configuration is written
// over an APB-style port (registers at 0x0, 0x4, 0x8); the user must write
// it only while idle, and the block itself does not enforce this.
module circular_log_address_tracker #(
   parameter int ID_BITS = 48
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Item input
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic [8:0]         req_log_length,
   // Result output
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_status,
   output logic [ID_BITS-1:0]      rsp_log_id,
   output logic [5:0]              rsp_at_dir,
   output logic [5:0]              rsp_at_file,
   output logic [11:0]             rsp_at_line,
   output logic [19:0]             rsp_at_position,
   output logic                    rsp_more_pending,
   output logic                    rsp_clear_dir_valid,
   output logic [5:0]              rsp_clear_dir_index,
   output logic                    rsp_checkpoint_due,
   output logic                    rsp_oldest_dropped,
   // Configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import clat_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [6:0]  num_dirs;
   logic [6:0]  files_per_dir;
   logic [12:0] logs_per_file;

   clat_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .num_dirs      (num_dirs),
      .files_per_dir (files_per_dir),
      .logs_per_file (logs_per_file)
   );

   clat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   clat_dp #(
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_log_length      (req_log_length),
      .num_dirs            (num_dirs),
      .files_per_dir       (files_per_dir),
      .logs_per_file       (logs_per_file),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_log_id          (rsp_log_id),
      .rsp_at_dir          (rsp_at_dir),
      .rsp_at_file         (rsp_at_file),
      .rsp_at_line         (rsp_at_line),
      .rsp_at_position     (rsp_at_position),
      .rsp_more_pending    (rsp_more_pending),
      .rsp_clear_dir_valid (rsp_clear_dir_valid),
      .rsp_clear_dir_index (rsp_clear_dir_index),
      .rsp_checkpoint_due  (rsp_checkpoint_due),
      .rsp_oldest_dropped  (rsp_oldest_dropped)
   );

endmodule

`default_nettype wire
